[sv/gts_pkg.sv]
// shared types and constants for the three-axis gyro smoother
`default_nettype none
package gts_pkg;

  localparam int SAMPLE_W = 16;
  localparam int RATE_W   = 17;
  localparam int NUM_AXES = 3;

  typedef struct packed {
    logic load1;
    logic smooth_wr;
    logic ring_wr;
    logic load2;
  } gts_lane_ctl_t;

  typedef struct packed {
    logic valid;
    logic ok;
    logic smooth;
  } gts_stage_t;

endpackage
`default_nettype wire

[sv/gts_in_if.sv]
// input word channel: six raw gyro bytes and the read flag
`default_nettype none
interface gts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] x_high;
  logic [7:0] x_low;
  logic [7:0] y_high;
  logic [7:0] y_low;
  logic [7:0] z_high;
  logic [7:0] z_low;
  logic       read_ok;

  modport source (
    output valid, x_high, x_low, y_high, y_low, z_high, z_low, read_ok,
    input  ready
  );
  modport sink (
    input  valid, x_high, x_low, y_high, y_low, z_high, z_low, read_ok,
    output ready
  );
endinterface
`default_nettype wire

[sv/gts_out_if.sv]
// result word channel: three filtered rates and status flags
`default_nettype none
interface gts_out_if import gts_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic signed [RATE_W-1:0] rate_x;
  logic signed [RATE_W-1:0] rate_y;
  logic signed [RATE_W-1:0] rate_z;
  logic                     sample_ok;
  logic                     from_smoother;

  modport source (
    output valid, rate_x, rate_y, rate_z, sample_ok, from_smoother,
    input  ready
  );
  modport sink (
    input  valid, rate_x, rate_y, rate_z, sample_ok, from_smoother,
    output ready
  );
endinterface
`default_nettype wire

[sv/gts_cfg_if.sv]
// configuration write channel carrying the mode bit
`default_nettype none
interface gts_cfg_if;
  logic valid;
  logic ready;
  logic smooth_mode;

  modport source (output valid, smooth_mode, input ready);
  modport sink (input valid, smooth_mode, output ready);
endinterface
`default_nettype wire

[sv/gts_lane.sv]
// one axis lane: smoothing history, sample ring with running sum, divide by depth
`default_nettype none
module gts_lane import gts_pkg::*; #(
  parameter int RING_DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire gts_lane_ctl_t              ctl,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  output logic [RATE_W-1:0]               quot,
  output logic                            neg,
  output logic signed [RATE_W-1:0]        smooth
);

  localparam int LG    = $clog2(RING_DEPTH);
  localparam int RW    = (RING_DEPTH > 1) ? LG : 1;
  localparam int SW    = SAMPLE_W + LG;
  localparam int K     = SW + LG;
  localparam int MW    = K + 1;
  localparam int PW    = SW + MW;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << K) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH));
  localparam logic [RW-1:0] LAST_POS = RW'(RING_DEPTH - 1);

  logic signed [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
  logic signed [SAMPLE_W-1:0] rd_r;
  logic [RW-1:0]              pos_r, pos_nxt;
  logic                       filled_r;
  logic signed [SW-1:0]       sum_r, sum_nxt;
  logic signed [SAMPLE_W-1:0] last_r, older_r;
  logic signed [SAMPLE_W-1:0] old_val;
  logic signed [17:0]         sum3, sum3r;
  logic [SW-1:0]              abs_nxt;
  logic [SW-1:0]              abs1_r;
  logic                       neg1_r, neg2_r;
  logic signed [RATE_W-1:0]   sm1_r, sm2_r;
  logic [PW-1:0]              prod;
  logic [RATE_W-1:0]          quot_r;

  always_comb begin
    old_val = filled_r ? rd_r : '0;
    sum_nxt = sum_r - SW'(old_val) + SW'(sample);
    abs_nxt = sum_nxt[SW-1] ? SW'(-sum_nxt) : SW'(sum_nxt);
    sum3    = 18'(sample) + 18'(last_r) + 18'(older_r);
    sum3r   = sum3 + {17'd0, sum3[17]};
    prod    = PW'(abs1_r) * PW'(RECIP);
    pos_nxt = pos_r;
    if (ctl.ring_wr) begin
      pos_nxt = (pos_r == LAST_POS) ? '0 : pos_r + RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ring_wr) begin
      ring_mem[pos_r[RW-1:0]] <= sample;
    end
    if (ctl.ring_wr && (pos_r == pos_nxt)) begin
      rd_r <= sample;
    end else begin
      rd_r <= ring_mem[pos_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      filled_r <= 1'b0;
      sum_r    <= '0;
      last_r   <= '0;
      older_r  <= '0;
    end else begin
      pos_r <= pos_nxt;
      if (ctl.ring_wr) begin
        sum_r <= sum_nxt;
        if (pos_r == LAST_POS) begin
          filled_r <= 1'b1;
        end
      end
      if (ctl.smooth_wr) begin
        older_r <= last_r;
        last_r  <= sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load1) begin
      abs1_r <= abs_nxt;
      neg1_r <= sum_nxt[SW-1];
      sm1_r  <= sum3r[17:1];
    end
    if (ctl.load2) begin
      quot_r <= prod[K +: RATE_W];
      neg2_r <= neg1_r;
      sm2_r  <= sm1_r;
    end
  end

  assign quot   = quot_r;
  assign neg    = neg2_r;
  assign smooth = sm2_r;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LAST_POS)
    else $error("ring position past last entry");

  a_smooth_keeps_ring: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.smooth_wr |=> $stable(pos_r) && $stable(sum_r))
    else $error("ring moved during smoothing write");

  a_wrap_fills: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ring_wr && pos_r == LAST_POS |=> filled_r && pos_r == '0)
    else $error("ring wrap not taken");

endmodule
`default_nettype wire

[sv/gts_merge.sv]
// output stage: combines lane results into one word, holds it while stalled
`default_nettype none
module gts_merge import gts_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire gts_stage_t               stg,
  input  wire logic [RATE_W-1:0]        quot   [NUM_AXES],
  input  wire logic                     neg    [NUM_AXES],
  input  wire logic signed [RATE_W-1:0] smooth [NUM_AXES],
  output logic                          take,
  gts_out_if.source                     out_ch
);

  logic                     valid_r;
  logic signed [RATE_W-1:0] rate_r [NUM_AXES];
  logic signed [RATE_W-1:0] rate_nxt [NUM_AXES];
  logic                     ok_r, from_sm_r;

  assign take = !valid_r || out_ch.ready;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      if (!stg.ok) begin
        rate_nxt[a] = '0;
      end else if (stg.smooth) begin
        rate_nxt[a] = smooth[a];
      end else if (neg[a]) begin
        rate_nxt[a] = -$signed(quot[a]);
      end else begin
        rate_nxt[a] = $signed(quot[a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= stg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rate_r    <= rate_nxt;
      ok_r      <= stg.ok;
      from_sm_r <= stg.ok && stg.smooth;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.rate_x        = rate_r[0];
  assign out_ch.rate_y        = rate_r[1];
  assign out_ch.rate_z        = rate_r[2];
  assign out_ch.sample_ok     = ok_r;
  assign out_ch.from_smoother = from_sm_r;

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !ok_r |-> rate_r[0] == '0 && rate_r[1] == '0 && rate_r[2] == '0)
    else $error("failed read word carries rates");

  a_smooth_ok: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && from_sm_r |-> ok_r)
    else $error("smoother flag on failed read");

  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    stg.valid && take |=> valid_r)
    else $error("lane word dropped at merge");

endmodule
`default_nettype wire

[sv/gyro_three_axis_smoother.sv]
// top level of the three-axis gyro rate smoother
// usage:
//   in_ch carries one gyro word per handshake: x/y/z high and low bytes and
//   read_ok. each axis is assembled big-endian into a signed 16-bit rate.
//   cfg_ch writes smooth_mode (always ready); write it only while idle.
//   out_ch returns one word per input word: rate_x/y/z, sample_ok and
//   from_smoother. a failed read returns all zeros and keeps filter state.
// throughput: one word per cycle unless out_ch stalls, set by the per-axis
//   running sum that swaps the ring sum for one subtract and add per word.
// pipeline: the lane update stage is loaded at accept, then the reciprocal
//   multiply stage for the divide by RING_DEPTH, then the output register
//   that drives out_ch.valid.
// reset: rst_n is synchronous active low; clears mode, ring position,
//   running sums and smoothing history. ring entries read as zero until
//   written, tracked by a wrap flag per lane, so no clearing pass is needed.
// stall: when out_ch.ready is low the output word holds; the two inner
//   stages keep filling, so up to three words are in flight before in_ch
//   ready drops.
`default_nettype none
module gyro_three_axis_smoother import gts_pkg::*; #(
  parameter int RING_DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  gts_in_if.sink    in_ch,
  gts_cfg_if.sink   cfg_ch,
  gts_out_if.source out_ch
);

  logic                       smooth_mode_r;
  gts_stage_t                 s1_r, s2_r;
  logic                       take3, take2, acc;
  gts_lane_ctl_t              lane_ctl;
  logic signed [SAMPLE_W-1:0] sample [NUM_AXES];
  logic [RATE_W-1:0]          quot   [NUM_AXES];
  logic                       neg    [NUM_AXES];
  logic signed [RATE_W-1:0]   smooth [NUM_AXES];

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_mode_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      smooth_mode_r <= cfg_ch.smooth_mode;
    end
  end

  assign take2       = !s2_r.valid || take3;
  assign in_ch.ready = !s1_r.valid || take2;
  assign acc         = in_ch.valid && in_ch.ready;

  assign sample[0] = $signed({in_ch.x_high, in_ch.x_low});
  assign sample[1] = $signed({in_ch.y_high, in_ch.y_low});
  assign sample[2] = $signed({in_ch.z_high, in_ch.z_low});

  always_comb begin
    lane_ctl.load1     = acc;
    lane_ctl.smooth_wr = acc && in_ch.read_ok && smooth_mode_r;
    lane_ctl.ring_wr   = acc && in_ch.read_ok && !smooth_mode_r;
    lane_ctl.load2     = take2;
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_r.ok     <= in_ch.read_ok;
      s1_r.smooth <= smooth_mode_r;
    end
    if (take2) begin
      s2_r.ok     <= s1_r.ok;
      s2_r.smooth <= s1_r.smooth;
    end
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
      s2_r.valid <= 1'b0;
    end else begin
      if (acc) begin
        s1_r.valid <= 1'b1;
      end else if (take2) begin
        s1_r.valid <= 1'b0;
      end
      if (take2) begin
        s2_r.valid <= s1_r.valid;
      end
    end
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    gts_lane #(
      .RING_DEPTH (RING_DEPTH)
    ) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (lane_ctl),
      .sample (sample[a]),
      .quot   (quot[a]),
      .neg    (neg[a]),
      .smooth (smooth[a])
    );
  end

  gts_merge u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .stg    (s2_r),
    .quot   (quot),
    .neg    (neg),
    .smooth (smooth),
    .take   (take3),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

[dv/gyro_three_axis_smoother_tb.sv]
// self-checking testbench for gyro_three_axis_smoother with a rate predictor
`default_nettype none
module gyro_three_axis_smoother_tb import gts_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_LEN    = 4;
  localparam int LATENCY     = 3;
  localparam int CYCLE_LIMIT = 200000;
  localparam bit RING_MODE   = 1'b0;
  localparam bit SMOOTH_MODE = 1'b1;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic        ok;
  } gyro_word_t;

  typedef struct packed {
    logic signed [RATE_W-1:0] rx;
    logic signed [RATE_W-1:0] ry;
    logic signed [RATE_W-1:0] rz;
    logic                     ok;
    logic                     smooth;
  } rate_word_t;

  logic clk;
  logic rst_n;

  gts_in_if  in_ch ();
  gts_cfg_if cfg_ch ();
  gts_out_if out_ch ();

  gyro_three_axis_smoother #(.RING_DEPTH(RING_LEN)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  // predictor state
  logic signed [15:0] ring_hist [3][RING_LEN];
  logic signed [15:0] last_hist [3];
  logic signed [15:0] older_hist [3];
  int                 ring_wr_pos;
  bit                 mode_q;

  rate_word_t expected_rates [$];
  int         error_count;
  int         cycle_count;
  int         burst_left;
  bit         gaps_on;
  bit         stall_on;
  logic [15:0] stall_mask;
  logic [3:0]  stall_ptr;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("gyro_three_axis_smoother_tb: errors");
      $finish;
    end
  end

  function automatic rate_word_t predict_rates(gyro_word_t w);
    rate_word_t r;
    int s [3];
    int res [3];
    int acc;
    int a;
    int k;
    r = '0;
    if (!w.ok) return r;
    s[0] = $signed(w.x);
    s[1] = $signed(w.y);
    s[2] = $signed(w.z);
    if (mode_q == SMOOTH_MODE) begin
      for (a = 0; a < 3; a++) begin
        res[a] = (s[a] + last_hist[a] + older_hist[a]) / 2;
        older_hist[a] = last_hist[a];
        last_hist[a] = 16'(s[a]);
      end
    end else begin
      for (a = 0; a < 3; a++) begin
        ring_hist[a][ring_wr_pos] = 16'(s[a]);
        acc = 0;
        for (k = 0; k < RING_LEN; k++) acc += ring_hist[a][k];
        res[a] = acc / RING_LEN;
      end
      ring_wr_pos = (ring_wr_pos + 1) % RING_LEN;
    end
    r.rx = RATE_W'(res[0]);
    r.ry = RATE_W'(res[1]);
    r.rz = RATE_W'(res[2]);
    r.ok = 1'b1;
    r.smooth = mode_q;
    return r;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // result checking, prediction on accept, register tracking
  always @(posedge clk) begin
    rate_word_t got;
    rate_word_t want;
    gyro_word_t w;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.rate_x, out_ch.rate_y, out_ch.rate_z,
                out_ch.sample_ok, out_ch.from_smoother};
        if (expected_rates.size() == 0) begin
          flag_mismatch("unexpected word rate_x", got.rx, 0);
        end else begin
          want = expected_rates.pop_front();
          if (got.rx !== want.rx) flag_mismatch("rate_x", got.rx, want.rx);
          if (got.ry !== want.ry) flag_mismatch("rate_y", got.ry, want.ry);
          if (got.rz !== want.rz) flag_mismatch("rate_z", got.rz, want.rz);
          if (got.ok !== want.ok) flag_mismatch("sample_ok", got.ok, want.ok);
          if (got.smooth !== want.smooth)
            flag_mismatch("from_smoother", got.smooth, want.smooth);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        w.x = {in_ch.x_high, in_ch.x_low};
        w.y = {in_ch.y_high, in_ch.y_low};
        w.z = {in_ch.z_high, in_ch.z_low};
        w.ok = in_ch.read_ok;
        expected_rates.push_back(predict_rates(w));
      end
      if (cfg_ch.valid && cfg_ch.ready) mode_q = cfg_ch.smooth_mode;
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (!stall_on) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= stall_mask[stall_ptr];
    end
    stall_ptr <= stall_ptr + 1'b1;
    if (stall_ptr == 4'hf) stall_mask <= 16'($urandom);
  end

  task automatic send_word(gyro_word_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (!gaps_on || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.x_high  <= w.x[15:8];
    in_ch.x_low   <= w.x[7:0];
    in_ch.y_high  <= w.y[15:8];
    in_ch.y_low   <= w.y[7:0];
    in_ch.z_high  <= w.z[15:8];
    in_ch.z_low   <= w.z[7:0];
    in_ch.read_ok <= w.ok;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_rates.size() != 0) @(posedge clk);
    repeat (LATENCY + 1) @(negedge clk);
  endtask

  task automatic write_mode(bit m);
    drain_results();
    @(negedge clk);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.smooth_mode <= m;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic gyro_word_t make_word(logic [15:0] x, logic [15:0] y,
                                           logic [15:0] z, logic ok);
    gyro_word_t w;
    w = '{x, y, z, ok};
    return w;
  endfunction

  function automatic logic [15:0] pick_axis();
    logic [15:0] v;
    case ($urandom_range(0, 7))
      0: v = 16'h7fff;
      1: v = 16'h8000;
      2: v = 16'hffff;
      3: v = 16'h0000;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  task automatic test_ring_extremes();
    write_mode(RING_MODE);
    repeat (4) send_word(make_word(16'h7fff, 16'h8000, 16'h0000, 1'b1));
    repeat (4) send_word(make_word(16'h8000, 16'h7fff, 16'hffff, 1'b1));
    send_word(make_word(16'hffff, 16'h0001, 16'h8001, 1'b1));
    send_word(make_word(16'hffff, 16'hffff, 16'hffff, 1'b0));
    send_word(make_word(16'h00ff, 16'hff00, 16'h5a5a, 1'b1));
  endtask

  task automatic test_smoothing();
    write_mode(SMOOTH_MODE);
    repeat (3) send_word(make_word(16'hffff, 16'h7fff, 16'h8000, 1'b1));
    repeat (3) send_word(make_word(16'h7fff, 16'h8000, 16'h0001, 1'b1));
    send_word(make_word(16'hffff, 16'hffff, 16'hffff, 1'b0));
    send_word(make_word(16'h0001, 16'hfffe, 16'h0003, 1'b1));
  endtask

  task automatic test_mode_switch();
    write_mode(RING_MODE);
    send_word(make_word(16'h1234, 16'hedcb, 16'h0000, 1'b1));
    send_word(make_word(16'h0000, 16'h0000, 16'h0000, 1'b0));
    write_mode(SMOOTH_MODE);
    send_word(make_word(16'h0000, 16'h0000, 16'h0000, 1'b1));
    send_word(make_word(16'h8000, 16'h7fff, 16'hffff, 1'b1));
  endtask

  task automatic test_random_traffic(int total);
    int sent;
    int n;
    gyro_word_t w;
    sent = 0;
    while (sent < total) begin
      write_mode(1'($urandom_range(0, 1)));
      gaps_on  = $urandom_range(0, 3) != 0;
      stall_on = $urandom_range(0, 3) != 0;
      n = $urandom_range(20, 90);
      repeat (n) begin
        w = make_word(pick_axis(), pick_axis(), pick_axis(), $urandom_range(0, 7) != 0);
        send_word(w);
      end
      sent += n;
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.x_high       = '0;
    in_ch.x_low        = '0;
    in_ch.y_high       = '0;
    in_ch.y_low        = '0;
    in_ch.z_high       = '0;
    in_ch.z_low        = '0;
    in_ch.read_ok      = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.smooth_mode = 1'b0;
    out_ch.ready       = 1'b1;
    stall_mask         = 16'($urandom);
    stall_ptr          = '0;
    gaps_on            = 1'b0;
    stall_on           = 1'b0;
    burst_left         = 0;
    error_count        = 0;
    cycle_count        = 0;
    mode_q             = RING_MODE;
    ring_wr_pos        = 0;
    for (int a = 0; a < 3; a++) begin
      last_hist[a]  = '0;
      older_hist[a] = '0;
      for (int k = 0; k < RING_LEN; k++) ring_hist[a][k] = '0;
    end
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    test_ring_extremes();
    gaps_on  = 1'b1;
    stall_on = 1'b1;
    test_smoothing();
    test_mode_switch();
    test_random_traffic(800);

    drain_results();
    repeat (LATENCY + 5) @(posedge clk);
    if (expected_rates.size() != 0)
      flag_mismatch("words never returned", 0, expected_rates.size());
    if (error_count == 0) begin
      $display("gyro_three_axis_smoother_tb: clean");
    end else begin
      $display("gyro_three_axis_smoother_tb: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

[files.f]
sv/gts_pkg.sv
sv/gts_in_if.sv
sv/gts_out_if.sv
sv/gts_cfg_if.sv
sv/gts_lane.sv
sv/gts_merge.sv
sv/gyro_three_axis_smoother.sv
dv/gyro_three_axis_smoother_tb.sv
